// File: rtl/qtir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtir_pkg
// Shared types and constants of the quarter-turn image rotator.
// ----------------------------------------------------------------------------
package qtir_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 13;
    localparam int DIM_W       = 7;
    localparam int COORD_W     = 6;
    localparam int PIX_W       = 24;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_LEFT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_TOP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_RIGHT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_BOTTOM     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DIRECTION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_COUNT     = 3'd7;

    // Command codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             last;
        logic             status;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
    } out_item_t;

endpackage

// File: rtl/quarter_turn_image_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_turn_image_rotator
// Frame store with raster load and quarter-turn raster readout.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the command transfers at a
//   rising edge with start high and busy low. A load (func 0) writes one pixel
//   into the frame store in raster order; busy stays low.
//   A read (func 1) goes as follows: source coordinates are registered in
//   the transfer cycle, the store address is formed and the store read in the
//   next (ST_RD_ADDR), and the result shows on result for one cycle, marked by
//   result_strobe, in ST_RD_DATA. Busy is high until the result cycle ends, so
//   a new read is taken only after the previous result has shown.
//   The receiver cannot stall; each result is taken in the cycle it shows.
//   Configuration channel: cfg_index/cfg_data transfer when cfg_valid and
//   cfg_ready are high. Each write triggers a resync (geometry decode in
//   ST_CALC, then a bit-serial divide in ST_DIV that turns the readout
//   position into a row and column); busy is high meanwhile, and a write
//   that lands during the resync restarts it.
//   Reset clears both positions, loads the default geometry (64 x 64, whole
//   image, no turn) and runs the same resync before the first command.
// ----------------------------------------------------------------------------
module quarter_turn_image_rotator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  qtir_pkg::in_item_t                  item,
    output logic                                result_strobe,
    output qtir_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qtir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qtir_pkg::DIM_W-1:0]          cfg_data
);

    localparam int DIM_W   = qtir_pkg::DIM_W;
    localparam int POS_W   = qtir_pkg::POS_W;
    localparam int COORD_W = qtir_pkg::COORD_W;
    localparam int ADDR_W  = qtir_pkg::ADDR_W;
    localparam int PIX_W   = qtir_pkg::PIX_W;
    localparam int DIV_STEPS = ADDR_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CALC    = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_RD_ADDR = 3'd3;
    localparam logic [2:0] ST_RD_DATA = 3'd4;

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(qtir_pkg::MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(qtir_pkg::MAX_HEIGHT);

    // Configuration registers
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [DIM_W-1:0] sel_left_reg, sel_top_reg, sel_right_reg, sel_bottom_reg;
    logic             turn_direction_reg;
    logic [2:0]       turn_count_reg;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] load_pos_reg, read_pos_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Decoded geometry
    logic [DIM_W-1:0] w_reg, h_reg, ow_reg, oh_reg, side_reg;
    logic [POS_W-1:0] total_reg;
    logic [1:0]       rot_reg;
    logic             whole_reg, status_reg, sub_reg;

    // Divider and read pipeline
    logic [ADDR_W-1:0]  dvd_reg;
    logic [DIM_W-1:0]   rem_reg;
    logic [COORD_W-1:0] sy_reg, sx_reg;
    logic               last_reg;
    logic [PIX_W-1:0]   rdata_reg;

    logic [PIX_W-1:0] frame_store [qtir_pkg::STORE_DEPTH];

    logic cmd_xfer, cfg_xfer, load_xfer, read_xfer;

    assign busy      = (state_reg != ST_IDLE);
    assign cmd_xfer  = start && !busy;
    assign load_xfer = cmd_xfer && (item.func == qtir_pkg::FUNC_LOAD);
    assign read_xfer = cmd_xfer && (item.func == qtir_pkg::FUNC_READ);
    assign cfg_ready = ((state_reg == ST_IDLE) && !start) ||
                       (state_reg == ST_CALC) || (state_reg == ST_DIV);
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // ---------------------------------------------------------------- decode
    logic [DIM_W-1:0]   w_c, h_c, ow_c, oh_c;
    logic [2*DIM_W-1:0] total_prod;
    logic [POS_W-1:0]   total_c, rp_c;
    logic [1:0]         rot_c;
    logic               whole_c, square_c, pos_side_c, outside_c;
    logic [DIM_W:0]     swd_c, shd_c;

    always_comb
    begin
        if (image_width_reg == '0)
            w_c = DIM_W'(1);
        else if (image_width_reg > MAX_W)
            w_c = MAX_W;
        else
            w_c = image_width_reg;
        if (image_height_reg == '0)
            h_c = DIM_W'(1);
        else if (image_height_reg > MAX_H)
            h_c = MAX_H;
        else
            h_c = image_height_reg;
        total_prod = w_c * h_c;
        total_c    = total_prod[POS_W-1:0];
        rot_c      = turn_direction_reg ? (2'd0 - turn_count_reg[1:0]) : turn_count_reg[1:0];
        whole_c    = (sel_bottom_reg == h_c && sel_top_reg == '0 &&
                      sel_right_reg == w_c && sel_left_reg == '0) ||
                     (sel_right_reg == h_c && sel_left_reg == '0 &&
                      sel_bottom_reg == w_c && sel_top_reg == '0);
        ow_c       = (whole_c && rot_c[0]) ? h_c : w_c;
        oh_c       = (whole_c && rot_c[0]) ? w_c : h_c;
        swd_c      = {1'b0, sel_right_reg} - {1'b0, sel_left_reg};
        shd_c      = {1'b0, sel_bottom_reg} - {1'b0, sel_top_reg};
        square_c   = (swd_c == shd_c);
        pos_side_c = !swd_c[DIM_W] && (swd_c != '0);
        outside_c  = (sel_right_reg > w_c) || (sel_bottom_reg > h_c);
        rp_c       = (read_pos_reg >= total_c) ? '0 : read_pos_reg;
    end

    // ----------------------------------------------------------- divide step
    logic [DIM_W:0]  div_trial;
    logic            div_ge;
    logic [DIM_W:0]  div_rem;

    always_comb
    begin
        div_trial = {rem_reg, dvd_reg[ADDR_W-1]};
        div_ge    = (div_trial >= {1'b0, ow_reg});
        div_rem   = div_ge ? (div_trial - {1'b0, ow_reg}) : div_trial;
    end

    // ------------------------------------------------------ source position
    logic [POS_W-1:0]   pos_eff, pos_inc, load_eff, load_inc;
    logic               last_c, in_sel, row_end;
    logic [COORD_W-1:0] ly, lx, lsy, lsx, s_m1, h_m1, w_m1, sy_c, sx_c;
    logic [DIM_W-1:0]   s_m1_w, h_m1_w, w_m1_w, ow_m1;

    always_comb
    begin
        pos_eff  = (read_pos_reg >= total_reg) ? '0 : read_pos_reg;
        pos_inc  = pos_eff + POS_W'(1);
        load_eff = (load_pos_reg >= total_reg) ? '0 : load_pos_reg;
        load_inc = load_eff + POS_W'(1);
        last_c  = (pos_eff == total_reg - POS_W'(1));
        ow_m1   = ow_reg - DIM_W'(1);
        row_end = ({1'b0, ox_reg} == ow_m1);
        in_sel  = ({1'b0, oy_reg} >= sel_top_reg) && ({1'b0, oy_reg} < sel_bottom_reg) &&
                  ({1'b0, ox_reg} >= sel_left_reg) && ({1'b0, ox_reg} < sel_right_reg);
        ly      = oy_reg - sel_top_reg[COORD_W-1:0];
        lx      = ox_reg - sel_left_reg[COORD_W-1:0];
        s_m1_w  = side_reg - DIM_W'(1);
        h_m1_w  = h_reg - DIM_W'(1);
        w_m1_w  = w_reg - DIM_W'(1);
        s_m1    = s_m1_w[COORD_W-1:0];
        h_m1    = h_m1_w[COORD_W-1:0];
        w_m1    = w_m1_w[COORD_W-1:0];
        unique case (rot_reg)
            2'd1:
            begin
                lsy = s_m1 - lx;
                lsx = ly;
            end
            2'd2:
            begin
                lsy = s_m1 - ly;
                lsx = s_m1 - lx;
            end
            2'd3:
            begin
                lsy = lx;
                lsx = s_m1 - ly;
            end
            default:
            begin
                lsy = ly;
                lsx = lx;
            end
        endcase
        sy_c = oy_reg;
        sx_c = ox_reg;
        if (whole_reg)
        begin
            unique case (rot_reg)
                2'd1:
                begin
                    sy_c = h_m1 - ox_reg;
                    sx_c = oy_reg;
                end
                2'd2:
                begin
                    sy_c = h_m1 - oy_reg;
                    sx_c = w_m1 - ox_reg;
                end
                2'd3:
                begin
                    sy_c = ox_reg;
                    sx_c = w_m1 - oy_reg;
                end
                default:
                begin
                    sy_c = oy_reg;
                    sx_c = ox_reg;
                end
            endcase
        end
        else if (sub_reg && in_sel)
        begin
            sy_c = lsy + sel_top_reg[COORD_W-1:0];
            sx_c = lsx + sel_left_reg[COORD_W-1:0];
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (read_xfer)
                    state_next = ST_RD_ADDR;
                else if (cfg_xfer)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                // A write landing now is missed by this decode; decode again
                if (cfg_xfer)
                    state_next = ST_CALC;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cfg_xfer)
                    state_next = ST_CALC;
                else if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_IDLE;
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CALC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CALC;
            image_width_reg    <= MAX_W;
            image_height_reg   <= MAX_H;
            sel_left_reg       <= '0;
            sel_top_reg        <= '0;
            sel_right_reg      <= MAX_W;
            sel_bottom_reg     <= MAX_H;
            turn_direction_reg <= 1'b0;
            turn_count_reg     <= '0;
            load_pos_reg       <= '0;
            read_pos_reg       <= '0;
            ox_reg             <= '0;
            oy_reg             <= '0;
            cnt_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes; out-of-list indexes cannot occur with a 3-bit index
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    qtir_pkg::REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                    qtir_pkg::REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                    qtir_pkg::REG_SEL_LEFT:       sel_left_reg       <= cfg_data;
                    qtir_pkg::REG_SEL_TOP:        sel_top_reg        <= cfg_data;
                    qtir_pkg::REG_SEL_RIGHT:      sel_right_reg      <= cfg_data;
                    qtir_pkg::REG_SEL_BOTTOM:     sel_bottom_reg     <= cfg_data;
                    qtir_pkg::REG_TURN_DIRECTION: turn_direction_reg <= cfg_data[0];
                    qtir_pkg::REG_TURN_COUNT:     turn_count_reg     <= cfg_data[2:0];
                    default:                      turn_count_reg     <= turn_count_reg;
                endcase
            end

            // Advance the load position, wrapping at the frame end
            if (load_xfer)
            begin
                if (load_inc >= total_reg)
                    load_pos_reg <= '0;
                else
                    load_pos_reg <= load_inc;
            end

            if (state_reg == ST_CALC)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    oy_reg <= dvd_reg[ADDR_W-2:0] == '0 && !div_ge ? '0 :
                              {dvd_reg[COORD_W-2:0], div_ge};
                    ox_reg <= div_rem[COORD_W-1:0];
                end
            end

            // Advance the readout position together with its row and column
            if (read_xfer)
            begin
                if (last_c)
                begin
                    read_pos_reg <= '0;
                    ox_reg       <= '0;
                    oy_reg       <= '0;
                end
                else
                begin
                    read_pos_reg <= pos_inc;
                    if (row_end)
                    begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + COORD_W'(1);
                    end
                    else
                        ox_reg <= ox_reg + COORD_W'(1);
                end
            end
        end
    end

    // Payload registers: geometry, divider, read pipeline
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            w_reg      <= w_c;
            h_reg      <= h_c;
            total_reg  <= total_c;
            rot_reg    <= rot_c;
            whole_reg  <= whole_c;
            ow_reg     <= ow_c;
            oh_reg     <= oh_c;
            side_reg   <= swd_c[DIM_W-1:0];
            status_reg <= !whole_c && (!square_c || (pos_side_c && outside_c));
            sub_reg    <= !whole_c && square_c && pos_side_c && !outside_c;
            dvd_reg    <= rp_c[ADDR_W-1:0];
            rem_reg    <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[ADDR_W-2:0], div_ge};
            rem_reg <= div_rem[DIM_W-1:0];
        end

        if (read_xfer)
        begin
            sy_reg   <= sy_c;
            sx_reg   <= sx_c;
            last_reg <= last_c;
        end
    end

    // Frame store: one write port for loads, one registered read port
    logic [2*DIM_W-1:0] row_base;
    logic [2*DIM_W-1:0] addr_sum;
    logic [ADDR_W-1:0]  load_addr;

    always_comb
    begin
        row_base  = {{DIM_W{1'b0}}, 1'b0, sy_reg} * {{DIM_W{1'b0}}, w_reg};
        addr_sum  = row_base + {{(DIM_W+1){1'b0}}, sx_reg};
        load_addr = load_eff[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_xfer)
            frame_store[load_addr] <= {item.red, item.green, item.blue};
        if (state_reg == ST_RD_ADDR)
            rdata_reg <= frame_store[addr_sum[ADDR_W-1:0]];
    end

    // Result shows for the one cycle of ST_RD_DATA
    assign result_strobe     = (state_reg == ST_RD_DATA);
    assign result.out_red    = rdata_reg[23:16];
    assign result.out_green  = rdata_reg[15:8];
    assign result.out_blue   = rdata_reg[7:0];
    assign result.last       = last_reg;
    assign result.status     = status_reg;
    assign result.out_width  = ow_reg;
    assign result.out_height = oh_reg;

endmodule
